[src/pcacc_pkg.sv]
// shared types, constants and helpers of the pixel covariance accumulator
package pcacc_pkg;

  localparam int NPIX    = 4096;
  localparam int PIX_W   = $clog2(NPIX);
  localparam int NNZ_MAX = 3;
  localparam int CSLOTS  = NNZ_MAX * (NNZ_MAX + 1) / 2;
  localparam int HPX_W   = 26;

  // configuration register indexes
  localparam logic [1:0] CFG_NNZ   = 2'd0;
  localparam logic [1:0] CFG_SIZE  = 2'd1;
  localparam logic [1:0] CFG_SCALE = 2'd2;
  localparam logic [1:0] CFG_MASK  = 2'd3;

  // item kinds
  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_MUL1,
    ST_MUL2,
    ST_RND,
    ST_DONE
  } pcacc_state_t;

  // pipeline enables, shared by all lanes
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
  } pcacc_lane_ctl_t;

  // row and column of a packed covariance slot
  function automatic logic [1:0] pair_row(input int m);
    case (m)
      0, 1, 2: pair_row = 2'd0;
      3, 4:    pair_row = 2'd1;
      default: pair_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pair_col(input int m);
    case (m)
      0:       pair_col = 2'd0;
      1, 3:    pair_col = 2'd1;
      default: pair_col = 2'd2;
    endcase
  endfunction

endpackage

[src/pcacc_ram.sv]
// generic single write port ram with registered read
module pcacc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/pcacc_lane.sv]
// one accumulation lane: product, rounding and saturating add
module pcacc_lane (
  input  logic                      clk,
  input  pcacc_pkg::pcacc_lane_ctl_t ctl,
  input  logic signed [31:0]        a,
  input  logic signed [23:0]        b,
  input  logic signed [63:0]        old_val,
  output logic signed [63:0]        new_val
);
  import pcacc_pkg::*;

  logic signed [55:0] prod_r;
  logic signed [42:0] rnd_r;
  logic signed [56:0] rsum;
  logic signed [63:0] inc;
  logic        [64:0] sum;

  // product register
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= a * b;
    end
  end

  // round half up, drop 14 fraction bits
  assign rsum = {prod_r[55], prod_r} + 57'sd8192;

  always_ff @(posedge clk) begin
    if (ctl.rnd_en) begin
      rnd_r <= rsum[56:14];
    end
  end

  // saturating add onto the stored value
  assign inc = {{21{rnd_r[42]}}, rnd_r};
  assign sum = {old_val[63], old_val} + {inc[63], inc};

  always_comb begin
    if (sum[64] != sum[63]) begin
      new_val = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      new_val = sum[63:0];
    end
  end

endmodule

[src/pixel_covariance_accumulator_core.sv]
// top level: sequencer, pixel stores, lanes and result merge
// each item steps through ADDR, MUL1, MUL2, RND and DONE; a read result is registered
// after DONE; a new item is taken only in idle, after the read, two multiply stages,
//   rounding and write-back of the pixel stores for the last item
// reset: a clearing pass over 4096 addresses zeroes all stores, busy is high meanwhile
// results cannot be stalled; each shows for one cycle with out_strobe
module pixel_covariance_accumulator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic signed [12:0] in_submap_index,
  input  logic signed [12:0] in_pixel_index,
  input  logic signed [15:0] in_weight_0,
  input  logic signed [15:0] in_weight_1,
  input  logic signed [15:0] in_weight_2,
  input  logic signed [23:0] in_sample_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output logic               out_strobe,
  output logic               out_of_range,
  output logic [31:0]        out_hit_count,
  output logic signed [63:0] out_zmap_0,
  output logic signed [63:0] out_zmap_1,
  output logic signed [63:0] out_zmap_2,
  output logic signed [63:0] out_cov_0,
  output logic signed [63:0] out_cov_1,
  output logic signed [63:0] out_cov_2,
  output logic signed [63:0] out_cov_3,
  output logic signed [63:0] out_cov_4,
  output logic signed [63:0] out_cov_5
);
  import pcacc_pkg::*;

  pcacc_state_t state_r, state_nxt;

  logic [1:0]         nnz_r;
  logic [12:0]        size_r;
  logic signed [15:0] scale_r;
  logic [2:0]         mask_r;

  logic               kind_r;
  logic signed [12:0] sub_r, pix_r;
  logic signed [15:0] w_r [NNZ_MAX];
  logic signed [23:0] sig_r;

  logic [PIX_W-1:0]   hpx_r;
  logic               bad_r;
  logic signed [31:0] ws_r [NNZ_MAX];

  logic [PIX_W-1:0]   clr_cnt_r;
  logic               clearing;
  logic               wr_item;
  logic [PIX_W-1:0]   waddr;

  logic [24:0]        mulp;
  logic [HPX_W-1:0]   hpx;
  logic [1:0]         n_eff;
  logic [NNZ_MAX-1:0] used;

  pcacc_lane_ctl_t    lane_ctl;

  logic [31:0]        hit_rd, hit_wd;
  logic               hit_we;
  logic signed [63:0] z_rd [NNZ_MAX];
  logic signed [63:0] z_new [NNZ_MAX];
  logic [63:0]        z_wd [NNZ_MAX];
  logic [NNZ_MAX-1:0] z_we;
  logic signed [63:0] c_rd [CSLOTS];
  logic signed [63:0] c_new [CSLOTS];
  logic [63:0]        c_wd [CSLOTS];
  logic [CSLOTS-1:0]  c_we;
  logic [CSLOTS-1:0]  c_used;

  logic               out_strobe_r, out_of_range_r;
  logic [31:0]        out_hit_r;
  logic signed [63:0] out_z_r [NNZ_MAX];
  logic signed [63:0] out_c_r [CSLOTS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nnz_r   <= 2'd3;
      size_r  <= 13'd256;
      scale_r <= 16'sd16384;
      mask_r  <= 3'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NNZ:   nnz_r   <= cfg_wdata[1:0];
        CFG_SIZE:  size_r  <= cfg_wdata[12:0];
        CFG_SCALE: scale_r <= cfg_wdata;
        CFG_MASK:  mask_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // sequencer state and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    lane_ctl.mul_en = 1'b0;
    lane_ctl.rnd_en = 1'b0;
    case (state_r)
      ST_CLEAR: if (&clr_cnt_r) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2: begin
        lane_ctl.mul_en = 1'b1;
        state_nxt       = ST_RND;
      end
      ST_RND: begin
        lane_ctl.rnd_en = 1'b1;
        state_nxt       = ST_DONE;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // item capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= in_kind;
      sub_r  <= in_submap_index;
      pix_r  <= in_pixel_index;
      w_r[0] <= in_weight_0;
      w_r[1] <= in_weight_1;
      w_r[2] <= in_weight_2;
      sig_r  <= in_sample_value;
    end
  end

  // pixel address and range check
  assign mulp = sub_r[11:0] * size_r;
  assign hpx  = {1'b0, mulp} + {{(HPX_W-12){1'b0}}, pix_r[11:0]};

  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      hpx_r <= hpx[PIX_W-1:0];
      bad_r <= sub_r[12] | pix_r[12] | (hpx >= HPX_W'(NPIX));
    end
  end

  // weight times scale, used by the zmap lanes and as row factor by the covariance lanes
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL1) begin
      for (int j = 0; j < NNZ_MAX; j++) begin
        ws_r[j] <= w_r[j] * scale_r;
      end
    end
  end

  // components in use
  assign n_eff = (nnz_r == 2'd0) ? 2'd1 : nnz_r;
  always_comb begin
    for (int j = 0; j < NNZ_MAX; j++) begin
      used[j] = (2'(j) < n_eff);
    end
    for (int m = 0; m < CSLOTS; m++) begin
      c_used[m] = used[pair_row(m)] & used[pair_col(m)];
    end
  end

  // store write control
  assign clearing = (state_r == ST_CLEAR);
  assign wr_item  = (state_r == ST_DONE) && (kind_r == KIND_ACC) && !bad_r;
  assign waddr    = clearing ? clr_cnt_r : hpx_r;

  assign hit_we = clearing | (wr_item & mask_r[0]);
  assign hit_wd = clearing ? 32'd0 : ((&hit_rd) ? hit_rd : hit_rd + 32'd1);

  pcacc_ram #(.WIDTH(32), .DEPTH(NPIX)) u_hit_ram (
    .clk   (clk),
    .we    (hit_we),
    .waddr (waddr),
    .wdata (hit_wd),
    .raddr (hpx_r),
    .rdata (hit_rd)
  );

  // zmap lanes
  for (genvar j = 0; j < NNZ_MAX; j++) begin : g_zlane
    logic [63:0] rd_raw;

    pcacc_ram #(.WIDTH(64), .DEPTH(NPIX)) u_ram (
      .clk   (clk),
      .we    (z_we[j]),
      .waddr (waddr),
      .wdata (z_wd[j]),
      .raddr (hpx_r),
      .rdata (rd_raw)
    );

    assign z_rd[j] = rd_raw;

    pcacc_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .a       (ws_r[j]),
      .b       (sig_r),
      .old_val (z_rd[j]),
      .new_val (z_new[j])
    );

    assign z_we[j] = clearing | (wr_item & mask_r[1] & used[j]);
    assign z_wd[j] = clearing ? 64'd0 : z_new[j];
  end

  // covariance lanes
  for (genvar m = 0; m < CSLOTS; m++) begin : g_clane
    logic [63:0] rd_raw;
    logic signed [23:0] wk;

    pcacc_ram #(.WIDTH(64), .DEPTH(NPIX)) u_ram (
      .clk   (clk),
      .we    (c_we[m]),
      .waddr (waddr),
      .wdata (c_wd[m]),
      .raddr (hpx_r),
      .rdata (rd_raw)
    );

    assign c_rd[m] = rd_raw;
    assign wk = {{8{w_r[pair_col(m)][15]}}, w_r[pair_col(m)]};

    pcacc_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .a       (ws_r[pair_row(m)]),
      .b       (wk),
      .old_val (c_rd[m]),
      .new_val (c_new[m])
    );

    assign c_we[m] = clearing | (wr_item & mask_r[2] & c_used[m]);
    assign c_wd[m] = clearing ? 64'd0 : c_new[m];
  end

  // result merge for read items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_DONE) && (kind_r == KIND_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_of_range_r <= bad_r;
      out_hit_r      <= bad_r ? 32'd0 : hit_rd;
      for (int j = 0; j < NNZ_MAX; j++) begin
        out_z_r[j] <= (bad_r || !used[j]) ? 64'sd0 : z_rd[j];
      end
      for (int m = 0; m < CSLOTS; m++) begin
        out_c_r[m] <= (bad_r || !c_used[m]) ? 64'sd0 : c_rd[m];
      end
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_of_range  = out_of_range_r;
  assign out_hit_count = out_hit_r;
  assign out_zmap_0    = out_z_r[0];
  assign out_zmap_1    = out_z_r[1];
  assign out_zmap_2    = out_z_r[2];
  assign out_cov_0     = out_c_r[0];
  assign out_cov_1     = out_c_r[1];
  assign out_cov_2     = out_c_r[2];
  assign out_cov_3     = out_c_r[3];
  assign out_cov_4     = out_c_r[4];
  assign out_cov_5     = out_c_r[5];

`ifndef SYNTHESIS
  // store writes only while clearing or finishing an item
  a_we_window: assert property (@(posedge clk) disable iff (!rst_n)
    (hit_we || (|z_we) || (|c_we)) |-> (state_r == ST_CLEAR || state_r == ST_DONE))
    else $error("store write outside clear or write-back");

  // a result follows the finish of a read item
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_DONE && $past(kind_r) == KIND_READ))
    else $error("result strobe without a finished read item");

  // an accepted item starts the address step
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_ADDR))
    else $error("accepted item did not start");

  // no item is taken during the clearing pass
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> busy)
    else $error("not busy while clearing");
`endif

endmodule

[sim/tb.sv]
// testbench of the pixel covariance accumulator core: directed table, random items, predictor
module tb;
  import pcacc_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_kind = KIND_ACC;
  logic signed [12:0] in_submap_index = '0;
  logic signed [12:0] in_pixel_index = '0;
  logic signed [15:0] in_weight_0 = '0;
  logic signed [15:0] in_weight_1 = '0;
  logic signed [15:0] in_weight_2 = '0;
  logic signed [23:0] in_sample_value = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_NNZ;
  logic [15:0]        cfg_wdata = '0;
  logic               out_strobe;
  logic               out_of_range;
  logic [31:0]        out_hit_count;
  logic signed [63:0] out_zmap_0, out_zmap_1, out_zmap_2;
  logic signed [63:0] out_cov_0, out_cov_1, out_cov_2, out_cov_3, out_cov_4, out_cov_5;

  pixel_covariance_accumulator_core DUT (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic               kind;
    logic signed [12:0] sub;
    logic signed [12:0] pix;
    logic signed [15:0] w [3];
    logic signed [23:0] sig;
  } sample_t;

  typedef struct {
    logic               oor;
    logic [31:0]        hits;
    logic signed [63:0] zmap [3];
    logic signed [63:0] cov [6];
  } pixel_read_t;

  // directed row: typed flag means the expected read is all zero with the given oor
  typedef struct {
    sample_t     s;
    bit          typed;
    logic        t_oor;
  } row_t;

  // covariance slot order: (0,0) (0,1) (0,2) (1,1) (1,2) (2,2)
  localparam int SLOT_ROW [6] = '{0, 0, 0, 1, 1, 2};
  localparam int SLOT_COL [6] = '{0, 1, 2, 1, 2, 2};

  // predictor state
  logic [31:0]        hit_model [NPIX];
  logic signed [63:0] zmap_model [NPIX*3];
  logic signed [63:0] cov_model [NPIX*6];
  logic [1:0]         m_nnz;
  logic [12:0]        m_size;
  logic signed [15:0] m_scale;
  logic [2:0]         m_mask;

  pixel_read_t pending_reads [$];
  int          n_errors = 0;

  function automatic longint round_q14(longint p);
    return (p + 64'sd8192) >>> 14;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63])
      return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    return s[63:0];
  endfunction

  // update stores for an accumulate item, or return the pixel contents for a read
  function automatic pixel_read_t pixel_update(sample_t s);
    pixel_read_t r;
    longint      hpx, ss, sw;
    int          n, idx;
    bit          bad;
    r.oor = 1'b0;
    r.hits = '0;
    for (int j = 0; j < 3; j++) r.zmap[j] = '0;
    for (int m = 0; m < 6; m++) r.cov[m] = '0;
    n = (m_nnz == 0) ? 1 : int'(m_nnz);
    bad = (s.sub < 0) || (s.pix < 0);
    hpx = longint'(s.sub) * longint'({1'b0, m_size}) + longint'(s.pix);
    if (!bad && hpx >= NPIX) bad = 1'b1;
    if (s.kind == KIND_ACC) begin
      if (bad) return r;
      if (m_mask[0] && hit_model[hpx] != 32'hffffffff) hit_model[hpx]++;
      if (m_mask[1]) begin
        ss = longint'(m_scale) * longint'(s.sig);
        for (int j = 0; j < n; j++) begin
          idx = int'(hpx) * 3 + j;
          zmap_model[idx] = add_sat(zmap_model[idx], round_q14(longint'(s.w[j]) * ss));
        end
      end
      if (m_mask[2]) begin
        for (int m = 0; m < 6; m++) begin
          if (SLOT_COL[m] < n) begin
            sw = longint'(s.w[SLOT_ROW[m]]) * longint'(m_scale);
            idx = int'(hpx) * 6 + m;
            cov_model[idx] = add_sat(cov_model[idx],
                                     round_q14(longint'(s.w[SLOT_COL[m]]) * sw));
          end
        end
      end
      return r;
    end
    if (bad) begin
      r.oor = 1'b1;
      return r;
    end
    r.hits = hit_model[hpx];
    for (int j = 0; j < n; j++) r.zmap[j] = zmap_model[int'(hpx) * 3 + j];
    for (int m = 0; m < 6; m++)
      if (SLOT_COL[m] < n) r.cov[m] = cov_model[int'(hpx) * 6 + m];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_read_t e;
    if (rst_n && out_strobe) begin
      if (pending_reads.size() == 0) begin
        report("result with no read waiting", 64'sd1, 64'sd0);
      end else begin
        e = pending_reads.pop_front();
        if (out_of_range !== e.oor) report("out_of_range", out_of_range, e.oor);
        if (out_hit_count !== e.hits) report("hit_count", out_hit_count, e.hits);
        if (out_zmap_0 !== e.zmap[0]) report("zmap_0", out_zmap_0, e.zmap[0]);
        if (out_zmap_1 !== e.zmap[1]) report("zmap_1", out_zmap_1, e.zmap[1]);
        if (out_zmap_2 !== e.zmap[2]) report("zmap_2", out_zmap_2, e.zmap[2]);
        if (out_cov_0 !== e.cov[0]) report("cov_0", out_cov_0, e.cov[0]);
        if (out_cov_1 !== e.cov[1]) report("cov_1", out_cov_1, e.cov[1]);
        if (out_cov_2 !== e.cov[2]) report("cov_2", out_cov_2, e.cov[2]);
        if (out_cov_3 !== e.cov[3]) report("cov_3", out_cov_3, e.cov[3]);
        if (out_cov_4 !== e.cov[4]) report("cov_4", out_cov_4, e.cov[4]);
        if (out_cov_5 !== e.cov[5]) report("cov_5", out_cov_5, e.cov[5]);
      end
    end
  end

  // send one item; entered and left at a falling edge
  task automatic send_item(sample_t s, bit typed, logic t_oor);
    pixel_read_t r;
    int          gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind = s.kind;
    in_submap_index = s.sub;
    in_pixel_index = s.pix;
    in_weight_0 = s.w[0];
    in_weight_1 = s.w[1];
    in_weight_2 = s.w[2];
    in_sample_value = s.sig;
    start = 1'b1;
    do @(posedge clk); while (busy);
    r = pixel_update(s);
    if (s.kind == KIND_READ) begin
      if (typed) begin
        r.oor = t_oor;
        r.hits = '0;
        for (int j = 0; j < 3; j++) r.zmap[j] = '0;
        for (int m = 0; m < 6; m++) r.cov[m] = '0;
      end
      pending_reads.push_back(r);
    end
    @(negedge clk);
  endtask

  // register write once the block has drained
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    start = 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_NNZ:   m_nnz = val[1:0];
      CFG_SIZE:  m_size = val[12:0];
      CFG_SCALE: m_scale = val;
      default:   m_mask = val[2:0];
    endcase
  endtask

  function automatic sample_t make_sample(logic kind, int sub, int pix, int w0, int w1, int w2,
                                          int sig);
    sample_t s;
    s.kind = kind;
    s.sub = 13'(sub);
    s.pix = 13'(pix);
    s.w[0] = 16'(w0);
    s.w[1] = 16'(w1);
    s.w[2] = 16'(w2);
    s.sig = 24'(sig);
    return s;
  endfunction

  // random item: mostly a few busy pixels, sometimes any field value
  function automatic sample_t random_sample();
    sample_t s;
    s.kind = ($urandom_range(0, 9) < 3) ? KIND_READ : KIND_ACC;
    if ($urandom_range(0, 9) < 8) begin
      s.sub = 13'($urandom_range(0, 3));
      s.pix = 13'($urandom_range(0, 7));
    end else begin
      s.sub = 13'($urandom);
      s.pix = 13'($urandom);
    end
    for (int j = 0; j < 3; j++) s.w[j] = 16'($urandom);
    s.sig = 24'($urandom);
    return s;
  endfunction

  // stimulus
  initial begin
    row_t        rows [$];
    logic [15:0] phases [8][4];
    for (int i = 0; i < NPIX; i++) hit_model[i] = '0;
    for (int i = 0; i < NPIX * 3; i++) zmap_model[i] = '0;
    for (int i = 0; i < NPIX * 6; i++) cov_model[i] = '0;
    m_nnz = 2'd3;
    m_size = 13'd256;
    m_scale = 16'sd16384;
    m_mask = 3'd7;

    // directed rows: reset contents, bad indexes, extremes
    rows.push_back('{make_sample(KIND_READ, 0, 0, 0, 0, 0, 0), 1, 1'b0});
    rows.push_back('{make_sample(KIND_READ, 15, 255, 0, 0, 0, 0), 1, 1'b0});
    rows.push_back('{make_sample(KIND_READ, -1, 0, 0, 0, 0, 0), 1, 1'b1});
    rows.push_back('{make_sample(KIND_READ, 0, -4096, 0, 0, 0, 0), 1, 1'b1});
    rows.push_back('{make_sample(KIND_READ, 16, 0, 0, 0, 0, 0), 1, 1'b1});
    rows.push_back('{make_sample(KIND_READ, 4095, 4095, 0, 0, 0, 0), 1, 1'b1});
    rows.push_back('{make_sample(KIND_ACC, -4096, 3, 100, 100, 100, 5), 0, 1'b0});
    rows.push_back('{make_sample(KIND_ACC, 3, -1, 100, 100, 100, 5), 0, 1'b0});
    rows.push_back('{make_sample(KIND_ACC, 16, 0, 100, 100, 100, 5), 0, 1'b0});
    rows.push_back('{make_sample(KIND_ACC, 0, 1, -32768, 32767, -32768, -8388608), 0, 1'b0});
    rows.push_back('{make_sample(KIND_ACC, 0, 1, 32767, -32768, 32767, 8388607), 0, 1'b0});
    rows.push_back('{make_sample(KIND_ACC, 0, 1, -32768, -32768, -32768, -8388608), 0, 1'b0});
    rows.push_back('{make_sample(KIND_ACC, 15, 255, 1, -1, 16384, 1), 0, 1'b0});
    rows.push_back('{make_sample(KIND_ACC, 15, 255, 8192, -8192, 0, -1), 0, 1'b0});
    rows.push_back('{make_sample(KIND_READ, 0, 1, 0, 0, 0, 0), 0, 1'b0});
    rows.push_back('{make_sample(KIND_READ, 15, 255, 0, 0, 0, 0), 0, 1'b0});
    rows.push_back('{make_sample(KIND_READ, 0, 3, 0, 0, 0, 0), 1, 1'b0});
    rows.push_back('{make_sample(KIND_READ, 3, 0, 0, 0, 0, 0), 1, 1'b0});

    // register settings per phase: nnz, submap size, scale, mask
    phases = '{'{16'd3, 16'd256, 16'h4000, 16'd7},
               '{16'd1, 16'd4096, 16'h7fff, 16'd7},
               '{16'd0, 16'd0, 16'h8000, 16'd6},
               '{16'd2, 16'd1, 16'hc000, 16'd5},
               '{16'hfffe, 16'hffff, 16'h0001, 16'd3},
               '{16'd3, 16'd8, 16'hffff, 16'hfffc},
               '{16'd2, 16'd5, 16'h1234, 16'd0},
               '{16'd3, 16'd4, 16'h8000, 16'd7}};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_item(rows[i].s, rows[i].typed, rows[i].t_oor);

    for (int p = 0; p < 8; p++) begin
      for (int r = 0; r < 4; r++) write_reg(r[1:0], phases[p][r]);
      repeat (100) send_item(random_sample(), 0, 1'b0);
    end
    start = 1'b0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // timeout
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
src/pcacc_pkg.sv
src/pcacc_ram.sv
src/pcacc_lane.sv
src/pixel_covariance_accumulator_core.sv
sim/tb.sv
